// ----- rtl/core/dmm_pkg.sv -----
// Shared constants and codes for the dense matrix multiply block.
`default_nettype none
package dmm_pkg;

  // Store bounds.
  localparam int MAX_ROWS  = 64;
  localparam int MAX_INNER = 32;
  localparam int MAX_COLS  = 64;

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  // Element and accumulator widths.
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 40;

  // Configuration port.
  localparam int NUM_REGS = 3;
  localparam int REG_IW   = $clog2(NUM_REGS);
  localparam int APB_AW   = REG_IW + 2;
  localparam int APB_DW   = 32;

  localparam logic [REG_IW-1:0] REG_ROWS  = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_INNER = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_COLS  = REG_IW'(2);

  // Item function codes.
  localparam logic [1:0] FUNC_WR_A    = 2'd0;
  localparam logic [1:0] FUNC_WR_B    = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/dmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/dense_matrix_multiply.sv -----
// Top level of the dense matrix multiply block: stores, sequencer and shared MAC.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o   | func_i, row_i, col_i, value_i
//   out      | out_valid_o / out_ready_i | product_value_o, out_row_o, out_col_o,
//            |                           | status_o
//   config   | APB (psel .. pready)      | rows_in_use, inner_in_use, cols_in_use
//
// A write item in range goes into its store as it is accepted. A compute item in range passes
// RUN, FLUSH and DONE before its result is loaded into the output register, where nk is
// inner_in_use clipped to MAX_INNER: one read of each store and one multiply-accumulate
// per inner step for nk steps in RUN, then FLUSH drains the pipeline. An out-of-range
// compute, or one with an inner size of zero, goes straight to DONE.
// The stores have no reset and need no clearing pass; reset clears the sequencer and
// the output valid and sets the configuration registers to the store bounds.
// A result waiting in the output register does not stop the next item from being
// accepted; a later compute holds its result until the output register is free.
`default_nettype none
module dense_matrix_multiply (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Item input.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [5:0]                    row_i,
  input  wire logic [5:0]                    col_i,
  input  wire logic signed [15:0]            value_i,
  // Result output.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [39:0]                 product_value_o,
  output logic [5:0]                         out_row_o,
  output logic [5:0]                         out_col_o,
  output logic                               status_o,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dmm_pkg::APB_AW-1:0]    paddr,
  input  wire logic [dmm_pkg::APB_DW-1:0]    pwdata,
  output logic      [dmm_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  import dmm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [6:0]               rows_cfg_q;
  logic [5:0]               inner_cfg_q;
  logic [6:0]               cols_cfg_q;
  logic [5:0]               req_row_q;
  logic [5:0]               req_col_q;
  logic [A_AW-1:0]          a_addr_q;
  logic [B_AW-1:0]          b_addr_q;
  logic [5:0]               k_q;
  logic                     rd_vld_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     status_q;
  logic                     out_valid_q;
  logic signed [ACC_W-1:0]  out_value_q;
  logic [5:0]               out_row_q;
  logic [5:0]               out_col_q;
  logic                     out_status_q;

  logic                     in_acc;
  logic                     cfg_wr;
  logic [REG_IW-1:0]        reg_idx;
  logic [5:0]               nk_eff;
  logic                     row_in_rows;
  logic                     row_in_inner;
  logic                     col_in_inner;
  logic                     col_in_cols;
  logic                     a_we;
  logic                     b_we;
  logic                     rd_en;
  logic                     last_step;
  logic                     out_free;
  logic signed [ELEM_W-1:0] a_rdata;
  logic signed [ELEM_W-1:0] b_rdata;
  logic [A_AW-1:0]          a_waddr;
  logic [B_AW-1:0]          b_waddr;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_ROWS:  prdata = APB_DW'(rows_cfg_q);
      REG_INNER: prdata = APB_DW'(inner_cfg_q);
      REG_COLS:  prdata = APB_DW'(cols_cfg_q);
      default:   prdata = '0;
    endcase
  end

  // Sizes in use are the register values clipped to the store bounds.
  assign nk_eff = (int'(inner_cfg_q) > MAX_INNER) ? 6'(MAX_INNER) : inner_cfg_q;

  assign row_in_rows  = ({1'b0, row_i} < rows_cfg_q) && (int'(row_i) < MAX_ROWS);
  assign row_in_inner = (row_i < inner_cfg_q) && (int'(row_i) < MAX_INNER);
  assign col_in_inner = (col_i < inner_cfg_q) && (int'(col_i) < MAX_INNER);
  assign col_in_cols  = ({1'b0, col_i} < cols_cfg_q) && (int'(col_i) < MAX_COLS);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign a_we    = in_acc && (func_i == FUNC_WR_A) && row_in_rows && col_in_inner;
  assign b_we    = in_acc && (func_i == FUNC_WR_B) && row_in_inner && col_in_cols;
  assign a_waddr = A_AW'(A_AW'(row_i) * A_AW'(MAX_INNER) + A_AW'(col_i));
  assign b_waddr = B_AW'(B_AW'(row_i) * B_AW'(MAX_COLS) + B_AW'(col_i));

  assign rd_en     = (state_q == S_RUN);
  assign last_step = (k_q == nk_eff - 6'd1);
  assign out_free  = !out_valid_q || out_ready_i;

  dmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (A_DEPTH)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (a_addr_q),
    .rdata_o (a_rdata)
  );

  dmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (B_DEPTH)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (b_addr_q),
    .rdata_o (b_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func_i == FUNC_COMPUTE)) begin
          if (row_in_rows && col_in_cols && (nk_eff != 6'd0)) begin
            state_d = S_RUN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RUN: begin
        if (last_step) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // Wait until the last product has reached the accumulator.
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_cfg_q  <= 7'd64;
      inner_cfg_q <= 6'd32;
      cols_cfg_q  <= 7'd64;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_en;
      prod_vld_q <= rd_vld_q;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_ROWS:  rows_cfg_q  <= pwdata[6:0];
          REG_INNER: inner_cfg_q <= pwdata[5:0];
          REG_COLS:  cols_cfg_q  <= pwdata[6:0];
          default: ;
        endcase
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: address walk, product register, accumulator and output register.
  always_ff @(posedge clk_i) begin
    if (in_acc && (func_i == FUNC_COMPUTE)) begin
      req_row_q <= row_i;
      req_col_q <= col_i;
      a_addr_q  <= A_AW'(A_AW'(row_i) * A_AW'(MAX_INNER));
      b_addr_q  <= B_AW'(col_i);
      k_q       <= 6'd0;
      acc_q     <= '0;
      status_q  <= !(row_in_rows && col_in_cols);
    end else begin
      if (rd_en) begin
        a_addr_q <= a_addr_q + A_AW'(1);
        b_addr_q <= b_addr_q + B_AW'(MAX_COLS);
        k_q      <= k_q + 6'd1;
      end
      if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (rd_vld_q) begin
      prod_q <= a_rdata * b_rdata;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_value_q  <= acc_q;
      out_row_q    <= req_row_q;
      out_col_q    <= req_col_q;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_value_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign status_o        = out_status_q;

endmodule
`default_nettype wire

// ----- tb/dense_matrix_multiply_test.sv -----
// Self-checking testbench for the dense matrix multiply block: stores, dot products, sizes.
`timescale 1ns / 100ps
module dense_matrix_multiply_test;
  import dmm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int DRAIN_CYCLES = MAX_INNER + 8;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } mm_op_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [5:0]              row;
    logic [5:0]              col;
    logic                    status;
  } c_elem_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               func_i = '0;
  logic [5:0]               row_i = '0;
  logic [5:0]               col_i = '0;
  logic signed [15:0]       value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [ACC_W-1:0]  product_value_o;
  logic [5:0]               out_row_o;
  logic [5:0]               out_col_o;
  logic                     status_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  dense_matrix_multiply uut (.*);

  // Matrix stores and sizes as the block should hold them.
  logic signed [ELEM_W-1:0] a_mat [A_DEPTH];
  logic signed [ELEM_W-1:0] b_mat [B_DEPTH];
  logic [6:0]               rows_cfg = 7'd64;
  logic [5:0]               inner_cfg = 6'd32;
  logic [6:0]               cols_cfg = 7'd64;

  // Entries that queued writes will have filled, so computes never read an empty entry.
  bit                       a_set [A_DEPTH];
  bit                       b_set [B_DEPTH];

  mm_op_t                   ops_to_send [$];
  c_elem_t                  c_elems_due [$];
  logic                     in_taken = 1'b0;
  int                       idle_pct = 27;
  int                       out_stall_requests = 0;
  int                       out_stall_served = 0;
  int                       out_stall_left = 0;
  int                       mismatches = 0;
  int                       items_accepted = 0;
  int                       elems_checked = 0;
  int                       oor_elems = 0;
  int                       size_settings = 0;
  int                       phase_items = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL dense_matrix_multiply");
    $finish;
  end

  function automatic int eff_rows();
    return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
  endfunction

  function automatic int eff_inner();
    return (inner_cfg > MAX_INNER) ? MAX_INNER : int'(inner_cfg);
  endfunction

  function automatic int eff_cols();
    return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
  endfunction

  // Stores a write item or works out the C element that a compute item asks for.
  task automatic apply_to_matrices(input mm_op_t op);
    c_elem_t res;
    longint  acc;
    int      nr;
    int      nk;
    int      nc;
    nr = eff_rows();
    nk = eff_inner();
    nc = eff_cols();
    case (op.func)
      FUNC_WR_A: if (op.row < nr && op.col < nk) a_mat[op.row * MAX_INNER + op.col] = op.value;
      FUNC_WR_B: if (op.row < nk && op.col < nc) b_mat[op.row * MAX_COLS + op.col] = op.value;
      FUNC_COMPUTE: begin
        acc = 0;
        res.status = 1'b1;
        if (op.row < nr && op.col < nc) begin
          res.status = 1'b0;
          for (int k = 0; k < nk; k++) begin
            acc += longint'(a_mat[op.row * MAX_INNER + k]) *
                   longint'(b_mat[k * MAX_COLS + op.col]);
          end
        end
        res.value = acc[ACC_W-1:0];
        res.row = op.row;
        res.col = op.col;
        c_elems_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit a_row_set(input int r);
    for (int k = 0; k < eff_inner(); k++) begin
      if (!a_set[r * MAX_INNER + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit b_col_set(input int c);
    for (int k = 0; k < eff_inner(); k++) begin
      if (!b_set[k * MAX_COLS + c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_op(input logic [1:0] f, input int r, input int c,
                          input logic signed [15:0] v);
    mm_op_t op;
    op.func = f;
    op.row = r[5:0];
    op.col = c[5:0];
    op.value = v;
    if (f == FUNC_WR_A && r < eff_rows() && c < eff_inner()) a_set[r * MAX_INNER + c] = 1'b1;
    if (f == FUNC_WR_B && r < eff_inner() && c < eff_cols()) b_set[r * MAX_COLS + c] = 1'b1;
    if (f != FUNC_UNUSED) phase_items++;
    ops_to_send.push_back(op);
  endtask

  // Loads row r of A and column c of B, then asks for C(r, c).
  task automatic queue_dot_product(input int r, input int c);
    logic signed [15:0] fixed_val;
    bit                 same;
    same = ($urandom_range(5) == 0);
    fixed_val = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
    for (int k = 0; k < eff_inner(); k++) begin
      queue_op(FUNC_WR_A, r, k, same ? fixed_val : pick_elem());
      queue_op(FUNC_WR_B, k, c, same ? fixed_val : pick_elem());
    end
    queue_op(FUNC_COMPUTE, r, c, pick_elem());
  endtask

  task automatic queue_random_step();
    int nr;
    int nc;
    int r;
    int c;
    int pick;
    bit found;
    nr = eff_rows();
    nc = eff_cols();
    pick = $urandom_range(99);
    if (pick < 35 && nr > 0 && nc > 0) begin
      queue_dot_product($urandom_range(nr - 1), $urandom_range(nc - 1));
    end else if (pick < 80 && nr > 0 && nc > 0) begin
      found = 1'b0;
      for (int tries = 0; tries < 16 && !found; tries++) begin
        r = $urandom_range(nr - 1);
        c = $urandom_range(nc - 1);
        found = a_row_set(r) && b_col_set(c);
      end
      if (found) queue_op(FUNC_COMPUTE, r, c, pick_elem());
      else queue_dot_product(r, c);
    end else if (pick < 95) begin
      // Loose items anywhere in the index space, many of them outside the sizes.
      r = $urandom_range(63);
      c = $urandom_range(63);
      case ($urandom_range(2))
        0: queue_op(FUNC_WR_A, r, c, pick_elem());
        1: queue_op(FUNC_WR_B, r, c, pick_elem());
        default: begin
          if (r >= nr || c >= nc || (a_row_set(r) && b_col_set(c)))
            queue_op(FUNC_COMPUTE, r, c, pick_elem());
        end
      endcase
    end else begin
      queue_op(FUNC_UNUSED, $urandom_range(63), $urandom_range(63), 16'($urandom));
    end
  endtask

  task automatic wait_for_drain();
    while (ops_to_send.size() != 0 || in_valid_i || c_elems_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Writes one size register over APB and reads it back.
  task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] mask;
    mask = (idx == REG_INNER) ? 32'h3F : 32'h7F;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== (data & mask)) begin
      $display("%0t: register %0d read back expected %0h, got %0h",
               $time, idx, data & mask, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROWS: rows_cfg = data[6:0];
      REG_INNER: inner_cfg = data[5:0];
      default: cols_cfg = data[6:0];
    endcase
  endtask

  task automatic set_sizes(input int r, input int k, input int c);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_ROWS, r);
    write_reg(REG_INNER, k);
    write_reg(REG_COLS, c);
    size_settings++;
  endtask

  // Item source.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (ops_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        {func_i, row_i, col_i, value_i} <= ops_to_send[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result sink; a requested hold-off keeps ready low for a long stretch.
  always @(negedge clk_i) begin
    if (out_stall_served != out_stall_requests) begin
      out_stall_served <= out_stall_served + 1;
      out_stall_left <= 400;
      out_ready_i <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    mm_op_t  taken_op;
    c_elem_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      taken_op = ops_to_send.pop_front();
      apply_to_matrices(taken_op);
      items_accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (c_elems_due.size() == 0) begin
        $display("%0t: unexpected C element (%0d,%0d) value %0d", $time,
                 out_row_o, out_col_o, product_value_o);
        mismatches++;
      end else begin
        want = c_elems_due.pop_front();
        elems_checked++;
        if (want.status) oor_elems++;
        if (product_value_o !== want.value) begin
          $display("%0t: C(%0d,%0d) value expected %0d, got %0d", $time,
                   want.row, want.col, want.value, product_value_o);
          mismatches++;
        end
        if (out_row_o !== want.row) begin
          $display("%0t: out_row expected %0d, got %0d", $time, want.row, out_row_o);
          mismatches++;
        end
        if (out_col_o !== want.col) begin
          $display("%0t: out_col expected %0d, got %0d", $time, want.col, out_col_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: C(%0d,%0d) status expected %0d, got %0d", $time,
                   want.row, want.col, want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int  r;
    int  k;
    int  c;
    bit  paused;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single inner step: extreme products, ignored writes, an unused code.
    set_sizes(64, 1, 64);
    queue_op(FUNC_WR_A, 63, 0, 16'sh8000);
    queue_op(FUNC_WR_B, 0, 63, 16'sh8000);
    queue_op(FUNC_COMPUTE, 63, 63, 16'sh7FFF);
    queue_op(FUNC_WR_A, 0, 0, 16'sh7FFF);
    queue_op(FUNC_WR_B, 0, 0, 16'sh7FFF);
    queue_op(FUNC_COMPUTE, 0, 0, 16'sh0000);
    queue_op(FUNC_COMPUTE, 0, 63, 16'sh0000);
    queue_op(FUNC_WR_A, 5, 0, -16'sd1);
    queue_op(FUNC_WR_A, 5, 1, 16'sh1234);
    queue_op(FUNC_WR_B, 1, 7, 16'sd5);
    queue_op(FUNC_COMPUTE, 5, 0, 16'sh0000);
    queue_op(FUNC_UNUSED, 63, 63, -16'sd1);
    queue_op(FUNC_COMPUTE, 63, 0, 16'sh0000);

    // One row by one column: requests and writes outside the sizes.
    set_sizes(1, 3, 1);
    queue_op(FUNC_WR_A, 0, 0, 16'sh7FFF);
    queue_op(FUNC_WR_A, 0, 1, 16'sh8000);
    queue_op(FUNC_WR_A, 0, 2, 16'sd1);
    queue_op(FUNC_WR_B, 0, 0, 16'sh8000);
    queue_op(FUNC_WR_B, 1, 0, 16'sh8000);
    queue_op(FUNC_WR_B, 2, 0, -16'sd1);
    queue_op(FUNC_COMPUTE, 0, 0, 16'sh0000);
    queue_op(FUNC_COMPUTE, 1, 0, 16'sh0000);
    queue_op(FUNC_COMPUTE, 0, 1, 16'sh0000);
    queue_op(FUNC_COMPUTE, 63, 63, 16'sh0000);
    queue_op(FUNC_WR_A, 1, 0, 16'sh4000);
    queue_op(FUNC_WR_B, 0, 1, 16'sh4000);

    paused = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin r = 64; k = 32; c = 64; end
        1: begin r = 1; k = 1; c = 1; end
        2: begin r = 100; k = 0; c = 127; end
        3: begin r = 0; k = 63; c = 1; end
        default: begin
          r = $urandom_range(1, 64);
          k = ($urandom_range(3) == 0) ? 32 : $urandom_range(1, 6);
          c = $urandom_range(1, 64);
        end
      endcase
      if (phase == 5) k = 2;
      set_sizes(r, k, c);
      idle_pct = (phase == 7) ? 0 : 27;
      // The sink stops for a while here so that results back up into the input.
      if (phase == 5) out_stall_requests++;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        queue_random_step();
        if (phase == 6 && phase_items >= PHASE_ITEMS / 2 && !paused) begin
          paused = 1'b1;
          wait_for_drain();
        end
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d items over %0d size settings; %0d C elements checked,",
             items_accepted, size_settings, elems_checked);
    $display("%0d of them requests outside the sizes.", oor_elems);
    if (mismatches == 0 && c_elems_due.size() == 0) begin
      $display("PASS dense_matrix_multiply");
    end else begin
      $display("FAIL dense_matrix_multiply");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dmm_pkg.sv
rtl/core/dmm_ram.sv
rtl/core/dense_matrix_multiply.sv
tb/dense_matrix_multiply_test.sv
